FILE: hw/rtl/lobm_pkg.sv
// lobm_pkg: word types, status codes and controller/datapath command structs
// for the limit order book matcher. No dependencies.
package lobm_pkg;

  localparam int BOOK_DEPTH = 64;
  localparam int PRICE_W    = 24;
  localparam int QTY_W      = 32;
  localparam int ID_W       = 64;
  localparam int CNT_W      = $clog2(BOOK_DEPTH + 1);

  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_TRADE    = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd3;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_MATCH = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

  typedef struct packed {
    logic               func;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [ID_W-1:0]    order_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [QTY_W-1:0]   trade_qty;
    logic [ID_W-1:0]    buy_id;
    logic [ID_W-1:0]    sell_id;
    logic [PRICE_W-1:0] bid_px;
    logic [PRICE_W-1:0] ask_px;
    logic [PRICE_W-1:0] top_bid;
    logic [PRICE_W-1:0] top_ask;
    logic [CNT_W-1:0]   bid_count;
    logic [CNT_W-1:0]   ask_count;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic add;        // append order
    logic scan_init;  // reset scan pointers
    logic scan_step;  // one scan step per side
    logic trade;      // latch trade and reduce
    logic rm_bid;     // one compaction step, bid side
    logic rm_ask;     // one compaction step, ask side
    logic no_bid;     // empty-bid match result
    logic no_ask;     // empty-ask match result
    logic no_cross;   // uncrossed result
    logic emit;       // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic func;
    logic side_full;
    logic bid_empty;
    logic ask_empty;
    logic scan_done;
    logic crossed;
    logic bid_rm_pend;
    logic ask_rm_pend;
  } stat_t;

endpackage

FILE: hw/rtl/lobm_datapath.sv
// lobm_datapath: order stores, best registers, scan and compaction logic.
// Depends on lobm_pkg.
module lobm_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  lobm_pkg::in_word_t    in_word,
  input  lobm_pkg::cmd_t        cmd,
  output lobm_pkg::stat_t       stat,
  output lobm_pkg::out_word_t   res
);
  localparam int DEPTH = lobm_pkg::BOOK_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = lobm_pkg::CNT_W;
  localparam int QW = lobm_pkg::QTY_W;
  localparam int IW = lobm_pkg::ID_W;
  localparam int PW = lobm_pkg::PRICE_W;
  localparam logic [PW-1:0] PMAX = '1;

  logic [PW-1:0] bp_mem [DEPTH];
  logic [QW-1:0] bq_mem [DEPTH];
  logic [IW-1:0] bi_mem [DEPTH];
  logic [PW-1:0] ap_mem [DEPTH];
  logic [QW-1:0] aq_mem [DEPTH];
  logic [IW-1:0] ai_mem [DEPTH];

  logic [CW-1:0] bid_n, ask_n;
  logic [PW-1:0] top_bid, top_ask;
  lobm_pkg::in_word_t cur;

  // scan: sequential read per step, registered read data
  logic [CW-1:0] scan_i;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rb_addr, ra_addr;
  logic [PW-1:0] rb_p, ra_p;
  logic [QW-1:0] rb_q, ra_q;
  logic [IW-1:0] rb_i, ra_i;
  logic rb_ok, ra_ok;
  logic [AW-1:0] hb, la;
  logic [PW-1:0] hb_p, la_p;
  logic [QW-1:0] hb_q, la_q;
  logic [IW-1:0] hb_i, la_i;
  logic hb_any, la_any;

  // compaction: read phase then write phase per moved entry
  logic [AW-1:0] rm_b, rm_a;
  logic bid_rm, ask_rm;
  logic mv_wr;

  lobm_pkg::out_word_t o;
  logic [QW-1:0] tq;
  logic [1:0] status;
  logic [QW-1:0] tq_r;
  logic [IW-1:0] bid_r, ask_r;
  logic [PW-1:0] bpr, spr;

  logic [CW-1:0] rbn, ran;
  assign rbn = CW'(rm_b) + CW'(1);
  assign ran = CW'(rm_a) + CW'(1);
  assign tq = (hb_q < la_q) ? hb_q : la_q;

  assign rd_idx  = scan_i[AW-1:0];
  assign rb_addr = bid_rm ? rbn[AW-1:0] : rd_idx;
  assign ra_addr = ask_rm ? ran[AW-1:0] : rd_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_word;
    if (cmd.add && cur.side == lobm_pkg::SIDE_BUY && bid_n < CW'(DEPTH)) begin
      bp_mem[bid_n[AW-1:0]] <= cur.price;
      bq_mem[bid_n[AW-1:0]] <= cur.qty;
      bi_mem[bid_n[AW-1:0]] <= cur.order_id;
    end
    if (cmd.add && cur.side == lobm_pkg::SIDE_SELL && ask_n < CW'(DEPTH)) begin
      ap_mem[ask_n[AW-1:0]] <= cur.price;
      aq_mem[ask_n[AW-1:0]] <= cur.qty;
      ai_mem[ask_n[AW-1:0]] <= cur.order_id;
    end
    rb_p <= bp_mem[rb_addr]; rb_q <= bq_mem[rb_addr]; rb_i <= bi_mem[rb_addr];
    ra_p <= ap_mem[ra_addr]; ra_q <= aq_mem[ra_addr]; ra_i <= ai_mem[ra_addr];
    if (cmd.trade) begin
      bq_mem[hb] <= hb_q - tq;
      aq_mem[la] <= la_q - tq;
    end
    if (cmd.rm_bid && bid_rm && mv_wr) begin
      bp_mem[rm_b] <= rb_p;
      bq_mem[rm_b] <= rb_q;
      bi_mem[rm_b] <= rb_i;
    end
    if (cmd.rm_ask && ask_rm && mv_wr) begin
      ap_mem[rm_a] <= ra_p;
      aq_mem[rm_a] <= ra_q;
      ai_mem[rm_a] <= ra_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bid_n <= '0; ask_n <= '0; top_bid <= '0; top_ask <= PMAX;
      scan_i <= '0; rd_vld <= 1'b0; hb_any <= 1'b0; la_any <= 1'b0;
      bid_rm <= 1'b0; ask_rm <= 1'b0; mv_wr <= 1'b0;
    end else begin
      if (cmd.add) begin
        if (cur.side == lobm_pkg::SIDE_BUY && bid_n < CW'(DEPTH)) begin
          bid_n <= bid_n + CW'(1);
          if (cur.price >= top_bid) top_bid <= cur.price;
        end
        if (cur.side == lobm_pkg::SIDE_SELL && ask_n < CW'(DEPTH)) begin
          ask_n <= ask_n + CW'(1);
          if (cur.price <= top_ask) top_ask <= cur.price;
        end
      end
      if (cmd.no_bid) top_bid <= '0;
      if (cmd.no_ask) top_ask <= PMAX;
      if (cmd.scan_init) begin
        scan_i <= '0; rd_vld <= 1'b0; hb_any <= 1'b0; la_any <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_i < CW'(DEPTH)) scan_i <= scan_i + CW'(1);
        rd_vld <= 1'b1;
        rb_ok <= scan_i < bid_n;
        ra_ok <= scan_i < ask_n;
        if (rd_vld) begin
          if (rb_ok && (!hb_any || rb_p > hb_p)) begin
            hb_any <= 1'b1; hb <= rd_idx - AW'(1);
            hb_p <= rb_p; hb_q <= rb_q; hb_i <= rb_i;
          end
          if (ra_ok && (!la_any || ra_p < la_p)) begin
            la_any <= 1'b1; la <= rd_idx - AW'(1);
            la_p <= ra_p; la_q <= ra_q; la_i <= ra_i;
          end
        end
      end
      if (cmd.trade) begin
        top_bid <= hb_p; top_ask <= la_p;
        bid_rm <= (hb_q == tq); ask_rm <= (la_q == tq);
        rm_b <= hb; rm_a <= la; mv_wr <= 1'b0;
      end
      if (cmd.rm_bid || cmd.rm_ask) mv_wr <= !mv_wr;
      if (cmd.rm_bid && bid_rm) begin
        if (mv_wr) rm_b <= rbn[AW-1:0];
        else if (rbn >= bid_n) begin
          bid_rm <= 1'b0; bid_n <= bid_n - CW'(1);
        end
      end
      if (cmd.rm_ask && ask_rm) begin
        if (mv_wr) rm_a <= ran[AW-1:0];
        else if (ran >= ask_n) begin
          ask_rm <= 1'b0; ask_n <= ask_n - CW'(1);
        end
      end
    end
  end

  // result latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status <= lobm_pkg::ST_NO_MATCH; tq_r <= '0; bid_r <= '0; ask_r <= '0;
      bpr <= '0; spr <= '0;
    end
    if (cmd.add) status <= (cur.side == lobm_pkg::SIDE_BUY ? bid_n : ask_n) <
                           CW'(DEPTH) ? lobm_pkg::ST_ADDED : lobm_pkg::ST_DROPPED;
    if (cmd.trade) begin
      status <= lobm_pkg::ST_TRADE; tq_r <= tq; bid_r <= hb_i; ask_r <= la_i;
      bpr <= hb_p; spr <= la_p;
    end
  end

  always_comb begin
    o.status    = status;
    o.trade_qty = tq_r;
    o.buy_id    = bid_r;
    o.sell_id   = ask_r;
    o.bid_px    = bpr;
    o.ask_px    = spr;
    o.top_bid   = top_bid;
    o.top_ask   = top_ask;
    o.bid_count = bid_n;
    o.ask_count = ask_n;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) res <= o;
  end

  always_comb begin
    stat.func        = cur.func;
    stat.side_full   = (cur.side == lobm_pkg::SIDE_BUY ? bid_n : ask_n) >= CW'(DEPTH);
    stat.bid_empty   = bid_n == '0;
    stat.ask_empty   = ask_n == '0;
    stat.scan_done   = rd_vld && (scan_i == CW'(DEPTH) ||
                       (scan_i > bid_n && scan_i > ask_n));
    stat.crossed     = hb_p >= la_p;
    stat.bid_rm_pend = bid_rm;
    stat.ask_rm_pend = ask_rm;
  end
endmodule

FILE: hw/rtl/lobm_ctrl.sv
// lobm_ctrl: sequencing state machine for add, scan, trade and compaction.
// Depends on lobm_pkg.
module lobm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output lobm_pkg::cmd_t   cmd,
  input  lobm_pkg::stat_t  stat
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TRD  = 3'd3;
  localparam logic [2:0] S_RM   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state, state_next;
  logic out_valid_next;

  // output word register frees the core; next item may start while held
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_next = S_DEC; end
      S_DEC: begin
        if (stat.func == lobm_pkg::FUNC_ADD) begin
          cmd.add = 1'b1; state_next = S_DONE;
        end else if (stat.bid_empty) begin
          cmd.no_bid = 1'b1; state_next = S_DONE;
        end else if (stat.ask_empty) begin
          cmd.no_ask = 1'b1; state_next = S_DONE;
        end else begin
          cmd.scan_init = 1'b1; state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_TRD;
      end
      S_TRD: begin
        if (stat.crossed) begin cmd.trade = 1'b1; state_next = S_RM; end
        else begin cmd.no_cross = 1'b1; state_next = S_DONE; end
      end
      S_RM: begin
        cmd.rm_bid = 1'b1; cmd.rm_ask = 1'b1;
        if (!stat.bid_rm_pend && !stat.ask_rm_pend) state_next = S_DONE;
      end
      S_DONE: if (!out_valid || out_ready) begin
        cmd.emit = 1'b1; state_next = S_IDLE;
      end
      S_EMIT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.emit) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      state <= state_next; out_valid <= out_valid_next;
    end
  end
endmodule

FILE: hw/rtl/limit_order_book_matcher.sv
// limit_order_book_matcher: top level joining controller and datapath.
// Depends on lobm_pkg, lobm_ctrl, lobm_datapath.
//
// Usage: in_word (func, side, price, qty, order_id) enters on in_valid/in_ready;
// exactly one result word per input word leaves on out_valid/out_ready.
// An add, or a match with an empty side, goes from decode straight to loading
// the result; the next word is taken in the cycle after the result is loaded.
// A match with both sides filled scans both stores together, one entry per
// cycle, then checks for a cross; on a trade, a filled order is compacted out
// by moving each later entry up, with a read phase then a write phase per entry.
// One item is in work at a time. The result sits in an output register, so
// the next word is accepted while an earlier result waits for out_ready;
// a stalled receiver stops the block only when a second result is ready.
// Reset (rst, synchronous) empties both sides, sets best bid to zero and
// best ask to all ones; no clearing pass is needed.
module limit_order_book_matcher (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lobm_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lobm_pkg::out_word_t  out_word
);
  lobm_pkg::cmd_t  cmd;
  lobm_pkg::stat_t stat;

  lobm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  lobm_datapath u_dp (
    .clk(clk), .rst(rst), .in_word(in_word), .cmd(cmd), .stat(stat), .res(out_word)
  );
endmodule

FILE: hw/rtl/lobm_checker.sv
// lobm_checker: port-level assertions for the matcher, bound to the top level.
// Depends on lobm_pkg and limit_order_book_matcher.
module lobm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lobm_pkg::out_word_t out_word
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_trade_cross: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status == lobm_pkg::ST_TRADE |->
      out_word.bid_px >= out_word.ask_px)
    else $error("trade without crossed prices");

  a_nontrade_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != lobm_pkg::ST_TRADE |->
      out_word.trade_qty == '0 && out_word.buy_id == '0 && out_word.sell_id == '0)
    else $error("trade fields set outside trade");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two words back to back");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);
